FILE: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and constants of the buddy block allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    localparam int LEVELS          = 15;
    localparam int MIN_BLOCK_BYTES = 32;
    localparam int POOL_BYTES      = 1024 * 1024;
    localparam int HEADER_BYTES    = 16;
    localparam int UNITS           = POOL_BYTES / MIN_BLOCK_BYTES;
    localparam int UNIT_W          = 15;
    localparam int LINK_W          = 16;
    localparam int LVL_W           = 4;
    localparam int SIZE_W          = 20;
    localparam int STEP_W          = 16;

    localparam logic [LINK_W-1:0] NIL         = '1;
    localparam logic [LVL_W-1:0]  LVL_UNKNOWN = 4'd15;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_status;

    typedef struct packed {
        logic              free;
        logic [LVL_W-1:0]  level;
        logic [LINK_W-1:0] next;
    } t_hdr;

endpackage

`default_nettype wire

FILE: rtl/bba_if.sv
// ----------------------------------------------------------------------------
// bba_if
// request and response channels of the buddy block allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bba_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [19:0] size_bytes;
    logic [14:0] block_unit;
    modport source (output valid, cmd, size_bytes, block_unit, input ready);
    modport sink   (input valid, cmd, size_bytes, block_unit, output ready);
endinterface

interface bba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [14:0] granted_unit;
    logic [3:0]  granted_level;
    modport source (output valid, status, granted_unit, granted_level, input ready);
    modport sink   (input valid, status, granted_unit, granted_level, output ready);
endinterface

`default_nettype wire

FILE: rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// generic single-clock ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// buddy allocator over a pool of 32-byte units, headers kept in one ram
// ----------------------------------------------------------------------------
// After reset the block sweeps all 32768 header ram entries and takes no
// request until then. Each request is then handled alone through a sequence
// of reads and writes on the single header ram port (one access per cycle,
// registered read data). An allocate searches the lists, does up to 14 splits
// (a read and two writes each) and pops a block; a free checks the header and,
// per merged level, reads the buddy and walks its list until it is found.
// Results wait in an output register, so a new request can be taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module buddy_block_allocator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bba_req_if.sink    i_req,
    bba_rsp_if.source  o_rsp
);
    import bba_pkg::*;

    typedef enum logic [17:0] {
        S_CLR   = 18'h00001,
        S_IDLE  = 18'h00002,
        S_ASRCH = 18'h00004,
        S_SPRD  = 18'h00008,
        S_SPWR1 = 18'h00010,
        S_SPWR2 = 18'h00020,
        S_POPRD = 18'h00040,
        S_POPWR = 18'h00080,
        S_FCHK  = 18'h00100,
        S_MRG   = 18'h00200,
        S_BCHK  = 18'h00400,
        S_WALK  = 18'h00800,
        S_WNXT  = 18'h01000,
        S_UNL   = 18'h02000,
        S_UP    = 18'h04000,
        S_PUSH  = 18'h08000,
        S_RESP  = 18'h10000,
        S_SPARE = 18'h20000
    } t_state;

    t_state              r_state, n_state;
    logic [UNIT_W-1:0]   r_clr, n_clr;
    logic [LINK_W-1:0]   r_head [LEVELS];
    logic [LINK_W-1:0]   n_head [LEVELS];
    logic [UNIT_W-1:0]   r_blk, n_blk;
    logic [UNIT_W-1:0]   r_buddy, n_buddy;
    logic [LVL_W-1:0]    r_lvl, n_lvl;
    logic [LVL_W-1:0]    r_want, n_want;
    t_hdr                r_bud, n_bud;
    t_hdr                r_bdata, n_bdata;
    t_hdr                r_pdata, n_pdata;
    logic [LINK_W-1:0]   r_prev, n_prev;
    logic [LINK_W-1:0]   r_cur, n_cur;
    logic [STEP_W-1:0]   r_steps, n_steps;
    t_status             r_rstat, n_rstat;
    logic [UNIT_W-1:0]   r_runit, n_runit;
    logic [LVL_W-1:0]    r_rlvl, n_rlvl;
    logic                r_ov;
    t_status             r_ostat;
    logic [UNIT_W-1:0]   r_ounit;
    logic [LVL_W-1:0]    r_olvl;

    logic                w_we, w_re;
    logic [UNIT_W-1:0]   w_waddr, w_raddr;
    t_hdr                w_wdata, w_rd, w_new;
    logic [$bits(t_hdr)-1:0] w_rdata;
    logic                w_load, w_found;
    logic [LVL_W-1:0]    w_fidx, w_calc;
    logic [SIZE_W:0]     w_need;
    logic [UNIT_W-1:0]   w_nblk;

    bba_ram #(
        .WIDTH ($bits(t_hdr)),
        .DEPTH (UNITS)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd        = t_hdr'(w_rdata);
    assign i_req.ready = (r_state == S_IDLE);
    assign w_load      = (r_state == S_RESP) && (!r_ov || o_rsp.ready);

    always_comb begin
        w_need = {1'b0, i_req.size_bytes} + (SIZE_W+1)'(HEADER_BYTES);
        w_calc = '0;
        for (int l = 0; l < LEVELS - 1; l++) begin
            if (((SIZE_W+1)'(MIN_BLOCK_BYTES) << l) < w_need) begin
                w_calc = w_calc + 4'd1;
            end
        end
        w_found = 1'b0;
        w_fidx  = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if ((LVL_W'(l) >= r_want) && (r_head[l] != NIL)) begin
                w_found = 1'b1;
                w_fidx  = LVL_W'(l);
            end
        end
        w_nblk = (r_blk > r_buddy) ? r_buddy : r_blk;
        w_new  = (r_blk > r_buddy) ? r_bud : r_bdata;
        w_new.level = r_lvl + 4'd1;
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_head  = r_head;
        n_blk   = r_blk;
        n_buddy = r_buddy;
        n_lvl   = r_lvl;
        n_want  = r_want;
        n_bud   = r_bud;
        n_bdata = r_bdata;
        n_pdata = r_pdata;
        n_prev  = r_prev;
        n_cur   = r_cur;
        n_steps = r_steps;
        n_rstat = r_rstat;
        n_runit = r_runit;
        n_rlvl  = r_rlvl;
        w_we    = 1'b0;
        w_waddr = r_blk;
        w_wdata = '{free: 1'b1, level: r_lvl, next: NIL};
        w_re    = 1'b0;
        w_raddr = r_blk;
        unique case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                if (r_clr == '0) begin
                    w_wdata = t_hdr'{free: 1'b1, level: LVL_W'(LEVELS - 1), next: NIL};
                end else begin
                    w_wdata = t_hdr'{free: 1'b0, level: LVL_UNKNOWN, next: NIL};
                end
                n_clr   = r_clr + 1'b1;
                if (r_clr == UNIT_W'(UNITS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_rstat = ST_OK;
                n_runit = '0;
                n_rlvl  = '0;
                if (i_req.valid) begin
                    if (i_req.cmd == CMD_ALLOC) begin
                        n_want = w_calc;
                        if ((i_req.size_bytes == '0) ||
                            (i_req.size_bytes > SIZE_W'(POOL_BYTES - HEADER_BYTES))) begin
                            n_rstat = ST_BAD_SIZE;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_ASRCH;
                        end
                    end else begin
                        n_blk   = i_req.block_unit;
                        w_re    = 1'b1;
                        w_raddr = i_req.block_unit;
                        n_state = S_FCHK;
                    end
                end
            end
            S_ASRCH: begin
                n_lvl = w_fidx;
                if (!w_found) begin
                    n_rstat = ST_NO_SPACE;
                    n_state = S_RESP;
                end else if (w_fidx > r_want) begin
                    n_state = S_SPRD;
                end else begin
                    n_state = S_POPRD;
                end
            end
            S_SPRD: begin
                n_blk   = r_head[r_lvl][UNIT_W-1:0];
                w_re    = 1'b1;
                w_raddr = r_head[r_lvl][UNIT_W-1:0];
                n_state = S_SPWR1;
            end
            S_SPWR1: begin
                n_head[r_lvl] = w_rd.next;
                n_buddy = r_blk + (UNIT_W'(1) << (r_lvl - 4'd1));
                w_we    = 1'b1;
                w_waddr = r_blk;
                w_wdata = '{free: 1'b1, level: r_lvl - 4'd1,
                            next: {1'b0, r_blk + (UNIT_W'(1) << (r_lvl - 4'd1))}};
                n_state = S_SPWR2;
            end
            S_SPWR2: begin
                w_we    = 1'b1;
                w_waddr = r_buddy;
                w_wdata = '{free: 1'b1, level: r_lvl - 4'd1, next: r_head[r_lvl - 4'd1]};
                n_head[r_lvl - 4'd1] = {1'b0, r_blk};
                n_lvl   = r_lvl - 4'd1;
                n_state = ((r_lvl - 4'd1) > r_want) ? S_SPRD : S_POPRD;
            end
            S_POPRD: begin
                n_blk   = r_head[r_want][UNIT_W-1:0];
                w_re    = 1'b1;
                w_raddr = r_head[r_want][UNIT_W-1:0];
                n_state = S_POPWR;
            end
            S_POPWR: begin
                n_head[r_want] = w_rd.next;
                w_we    = 1'b1;
                w_waddr = r_blk;
                w_wdata = '{free: 1'b0, level: w_rd.level, next: NIL};
                n_runit = r_blk;
                n_rlvl  = r_want;
                n_state = S_RESP;
            end
            S_FCHK: begin
                if ((w_rd.level == LVL_UNKNOWN) || w_rd.free) begin
                    n_rstat = ST_BAD_FREE;
                    n_state = S_RESP;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_blk;
                    w_wdata = '{free: 1'b1, level: w_rd.level, next: w_rd.next};
                    n_bdata = '{free: 1'b1, level: w_rd.level, next: w_rd.next};
                    n_lvl   = w_rd.level;
                    n_state = S_MRG;
                end
            end
            S_MRG: begin
                if (r_lvl >= LVL_W'(LEVELS - 1)) begin
                    n_state = S_PUSH;
                end else begin
                    n_buddy = r_blk ^ (UNIT_W'(1) << r_lvl);
                    w_re    = 1'b1;
                    w_raddr = r_blk ^ (UNIT_W'(1) << r_lvl);
                    n_state = S_BCHK;
                end
            end
            S_BCHK: begin
                n_bud = w_rd;
                if (!w_rd.free || (w_rd.level != r_lvl)) begin
                    n_state = S_PUSH;
                end else begin
                    n_prev  = NIL;
                    n_cur   = r_head[r_lvl];
                    n_steps = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!r_cur[LINK_W-1] && (r_cur[UNIT_W-1:0] != r_buddy)) begin
                    if (({1'b0, r_steps} + 17'd1) > 17'(UNITS)) begin
                        n_state = S_PUSH;
                    end else begin
                        n_steps = r_steps + 1'b1;
                        n_prev  = r_cur;
                        w_re    = 1'b1;
                        w_raddr = r_cur[UNIT_W-1:0];
                        n_state = S_WNXT;
                    end
                end else if (!r_cur[LINK_W-1]) begin
                    n_state = S_UNL;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_WNXT: begin
                n_pdata = w_rd;
                n_cur   = w_rd.next;
                n_state = S_WALK;
            end
            S_UNL: begin
                if (r_prev[LINK_W-1]) begin
                    n_head[r_lvl] = r_bud.next;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_prev[UNIT_W-1:0];
                    w_wdata = '{free: r_pdata.free, level: r_pdata.level, next: r_bud.next};
                    if (r_prev[UNIT_W-1:0] == r_blk) begin
                        n_bdata.next = r_bud.next;
                    end
                end
                n_state = S_UP;
            end
            S_UP: begin
                w_we    = 1'b1;
                w_waddr = w_nblk;
                w_wdata = w_new;
                n_bdata = w_new;
                n_blk   = w_nblk;
                n_lvl   = r_lvl + 4'd1;
                n_state = S_MRG;
            end
            S_PUSH: begin
                w_we    = 1'b1;
                w_waddr = r_blk;
                w_wdata = '{free: 1'b1, level: r_lvl, next: r_head[r_lvl]};
                n_head[r_lvl] = {1'b0, r_blk};
                n_runit = r_blk;
                n_rlvl  = r_lvl;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l] <= (l == LEVELS - 1) ? '0 : NIL;
            end
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_head  <= n_head;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk   <= n_blk;
        r_buddy <= n_buddy;
        r_lvl   <= n_lvl;
        r_want  <= n_want;
        r_bud   <= n_bud;
        r_bdata <= n_bdata;
        r_pdata <= n_pdata;
        r_prev  <= n_prev;
        r_cur   <= n_cur;
        r_steps <= n_steps;
        r_rstat <= n_rstat;
        r_runit <= n_runit;
        r_rlvl  <= n_rlvl;
        if (w_load) begin
            r_ostat <= r_rstat;
            r_ounit <= r_runit;
            r_olvl  <= r_rlvl;
        end
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.status        = r_ostat;
    assign o_rsp.granted_unit  = r_ounit;
    assign o_rsp.granted_level = r_olvl;

    // ram port never reads and writes one entry in the same cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_re) |-> (w_waddr != w_raddr))
        else $error("header ram read and write collide");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_OK)) |->
        ((o_rsp.granted_unit == '0) && (o_rsp.granted_level == '0)))
        else $error("failed request carries a block");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != S_IDLE))
        else $error("accepted request dropped");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ({1'b0, r_steps} <= 17'(UNITS)))
        else $error("list walk overran its bound");

endmodule

`default_nettype wire
